// ----- hdl/brfa_pkg.sv -----
`default_nettype none

package brfa_pkg;

    // Fixed field widths
    localparam int OFFSET_BITS = 16;
    localparam int LEN_BITS    = OFFSET_BITS + 1;
    localparam int FREE_BITS   = 6;

    // Request modes
    localparam logic [1:0] MODE_ALLOC   = 2'd0;
    localparam logic [1:0] MODE_RELEASE = 2'd1;
    localparam logic [1:0] MODE_REINIT  = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    // One free block in the table
    typedef struct packed {
        logic [OFFSET_BITS-1:0] start;
        logic [LEN_BITS-1:0]    length;
    } t_entry;

endpackage

`default_nettype wire

// ----- hdl/brfa_ifs.sv -----
`default_nettype none

// Request word: mode, size and offset
interface brfa_req_if;
    logic                            valid;
    logic                            ready;
    logic [1:0]                      mode;
    logic [brfa_pkg::OFFSET_BITS-1:0] req_size;
    logic [brfa_pkg::OFFSET_BITS-1:0] req_offset;

    modport source (output valid, output mode, output req_size, output req_offset,
                    input ready);
    modport sink   (input valid, input mode, input req_size, input req_offset,
                    output ready);
endinterface

// Result word: status, granted offset and free block count
interface brfa_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [1:0]                       status;
    logic [brfa_pkg::OFFSET_BITS-1:0] alloc_offset;
    logic [brfa_pkg::FREE_BITS-1:0]   free_blocks;

    modport source (output valid, output status, output alloc_offset, output free_blocks,
                    input ready);
    modport sink   (input valid, input status, input alloc_offset, input free_blocks,
                    output ready);
endinterface

// Capacity register write word
interface brfa_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [brfa_pkg::OFFSET_BITS-1:0] arena_capacity;

    modport source (output valid, output arena_capacity, input ready);
    modport sink   (input valid, input arena_capacity, output ready);
endinterface

`default_nettype wire

// ----- hdl/best_fit_range_allocator.sv -----
`default_nettype none

// Best-fit allocator for a byte region, keeping a table of up to TABLE_ENTRIES free
// blocks in a table memory with a valid flag per entry. Allocate and release words of
// nonzero size that are in range walk the whole table, one entry per cycle through the
// memory read port: a first step starts the read, then each entry is read in turn, then
// the update step writes back at most one entry, and the result is registered last.
// Zero-size words, out-of-range words, unused modes and reinit skip the walk. The
// request side is ready again in the cycle the result is registered. The capacity
// register takes effect only at reinit, as reset sets the capacity to all ones; after
// reset the init state loads the first table entry before requests are taken. The
// request side is ready only while no word is in progress; a finished result waits in
// the output register and does not block the next request, but while that register
// is still held the next result waits in the sequencer and the block stays busy.
module best_fit_range_allocator #(
    parameter int TABLE_ENTRIES = 32
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    brfa_cfg_if.sink    i_cfg,
    brfa_req_if.sink    i_req,
    brfa_rsp_if.source  o_rsp
);

    localparam int OW = brfa_pkg::OFFSET_BITS;
    localparam int LW = brfa_pkg::LEN_BITS;
    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);

    // Sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_INIT = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_UPD  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]                 r_state;
    logic                       r_init_res;
    logic [1:0]                 r_mode;
    logic [OW-1:0]              r_size;
    logic [OW-1:0]              r_off;
    logic [LW-1:0]              r_end;
    logic [OW-1:0]              r_cfg_cap;
    logic [OW-1:0]              r_cap;
    logic [TABLE_ENTRIES-1:0]   r_valid;
    logic [CW-1:0]              r_count;

    // Table memory
    brfa_pkg::t_entry           r_mem [TABLE_ENTRIES];
    brfa_pkg::t_entry           r_rd;

    // Scan pipeline
    logic [IW-1:0]              r_idx;
    logic                       r_issue;
    logic                       r_stg_vld;
    logic [IW-1:0]              r_stg_idx;

    // Scan findings
    logic                       r_found;
    logic [IW-1:0]              r_best_idx;
    logic [OW-1:0]              r_best_start;
    logic [LW-1:0]              r_best_len;
    logic                       r_overlap;
    logic                       r_pred;
    logic [IW-1:0]              r_pred_idx;
    logic [OW-1:0]              r_pred_start;
    logic [LW-1:0]              r_pred_len;
    logic                       r_succ;
    logic [IW-1:0]              r_succ_idx;
    logic [LW-1:0]              r_succ_len;
    logic                       r_slot;
    logic [IW-1:0]              r_slot_idx;

    // Result and output register
    logic [1:0]                 r_status;
    logic [OW-1:0]              r_grant;
    logic                       r_o_vld;
    logic [1:0]                 r_o_status;
    logic [OW-1:0]              r_o_grant;
    logic [brfa_pkg::FREE_BITS-1:0] r_o_free;

    logic                       req_acc;
    logic [2:0]                 acc_state;
    logic [1:0]                 acc_status;
    logic [LW-1:0]              acc_end;
    logic                       stg_valid;
    logic [LW-1:0]              stg_end;
    logic                       fits;
    logic                       better;
    logic [LW-1:0]              size_ext;
    logic                       mem_we;
    logic [IW-1:0]              mem_waddr;
    brfa_pkg::t_entry           mem_wdata;
    logic [1:0]                 upd_status;
    logic                       upd_clr;
    logic [IW-1:0]              upd_clr_idx;
    logic                       upd_set;
    logic                       out_free;
    logic [CW+brfa_pkg::FREE_BITS-1:0] count_ext;

    assign i_cfg.ready = 1'b1;
    assign i_req.ready = (r_state == S_IDLE);
    assign req_acc     = i_req.valid && (r_state == S_IDLE);
    assign out_free    = !r_o_vld || o_rsp.ready;
    assign size_ext    = {1'b0, r_size};
    assign count_ext   = {{brfa_pkg::FREE_BITS{1'b0}}, r_count};
    assign acc_end     = {1'b0, i_req.req_offset} + {1'b0, i_req.req_size};

    assign o_rsp.valid        = r_o_vld;
    assign o_rsp.status       = r_o_status;
    assign o_rsp.alloc_offset = r_o_grant;
    assign o_rsp.free_blocks  = r_o_free;

    // Where an accepted word goes next, and its early status
    always_comb begin
        acc_state  = S_DONE;
        acc_status = brfa_pkg::ST_OK;
        case (i_req.mode)
            brfa_pkg::MODE_ALLOC: begin
                if (i_req.req_size > r_cap) begin
                    acc_status = brfa_pkg::ST_NOFIT;
                end else if (i_req.req_size != '0) begin
                    acc_state = S_SCAN;
                end
            end
            brfa_pkg::MODE_RELEASE: begin
                if (i_req.req_size != '0) begin
                    if (acc_end > {1'b0, r_cap}) begin
                        acc_status = brfa_pkg::ST_RANGE;
                    end else begin
                        acc_state = S_SCAN;
                    end
                end
            end
            brfa_pkg::MODE_REINIT: begin
                acc_state = S_INIT;
            end
            default: begin
                acc_state = S_DONE;
            end
        endcase
    end

    // Entry under evaluation in the scan
    assign stg_valid = r_valid[r_stg_idx];
    assign stg_end   = {1'b0, r_rd.start} + r_rd.length;
    assign fits      = r_rd.length >= size_ext;
    assign better    = !r_found || (r_rd.length < r_best_len) ||
                       ((r_rd.length == r_best_len) && (r_rd.start < r_best_start));

    // Table write-back and the update decision
    always_comb begin
        mem_we      = 1'b0;
        mem_waddr   = '0;
        mem_wdata   = '{start: '0, length: {1'b0, r_cap}};
        upd_status  = brfa_pkg::ST_OK;
        upd_clr     = 1'b0;
        upd_clr_idx = '0;
        upd_set     = 1'b0;
        if (r_state == S_INIT) begin
            mem_we = 1'b1;
        end else if (r_state == S_UPD) begin
            if (r_mode == brfa_pkg::MODE_ALLOC) begin
                if (!r_found) begin
                    upd_status = brfa_pkg::ST_NOFIT;
                end else if (r_best_len > size_ext) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_best_idx;
                    mem_wdata = '{start: r_best_start + r_size, length: r_best_len - size_ext};
                end else begin
                    upd_clr     = 1'b1;
                    upd_clr_idx = r_best_idx;
                end
            end else begin
                if (r_overlap) begin
                    upd_status = brfa_pkg::ST_RANGE;
                end else if (r_pred && r_succ) begin
                    mem_we      = 1'b1;
                    mem_waddr   = r_pred_idx;
                    mem_wdata   = '{start: r_pred_start,
                                    length: r_pred_len + size_ext + r_succ_len};
                    upd_clr     = 1'b1;
                    upd_clr_idx = r_succ_idx;
                end else if (r_pred) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_pred_idx;
                    mem_wdata = '{start: r_pred_start, length: r_pred_len + size_ext};
                end else if (r_succ) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_succ_idx;
                    mem_wdata = '{start: r_off, length: r_succ_len + size_ext};
                end else if (r_slot) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_slot_idx;
                    mem_wdata = '{start: r_off, length: size_ext};
                    upd_set   = 1'b1;
                end else begin
                    upd_status = brfa_pkg::ST_FULL;
                end
            end
        end
    end

    // Free block table: one write, one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd <= r_mem[r_idx];
    end

    // Capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_cap <= '1;
        end else if (i_cfg.valid) begin
            r_cfg_cap <= i_cfg.arena_capacity;
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_INIT;
            r_init_res <= 1'b0;
            r_cap      <= '1;
            r_valid    <= '0;
            r_count    <= '0;
            r_issue    <= 1'b0;
            r_stg_vld  <= 1'b0;
            r_o_vld    <= 1'b0;
        end else begin
            // the sequencer refills the output register itself when done
            if (r_o_vld && o_rsp.ready && (r_state != S_DONE)) begin
                r_o_vld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (req_acc) begin
                        r_mode     <= i_req.mode;
                        r_size     <= i_req.req_size;
                        r_off      <= i_req.req_offset;
                        r_end      <= acc_end;
                        r_grant    <= '0;
                        r_status   <= acc_status;
                        r_idx      <= '0;
                        r_issue    <= 1'b1;
                        r_stg_vld  <= 1'b0;
                        r_found    <= 1'b0;
                        r_overlap  <= 1'b0;
                        r_pred     <= 1'b0;
                        r_succ     <= 1'b0;
                        r_slot     <= 1'b0;
                        r_state    <= acc_state;
                        if (i_req.mode == brfa_pkg::MODE_REINIT) begin
                            r_cap      <= r_cfg_cap;
                            r_init_res <= 1'b1;
                        end
                    end
                end
                S_INIT: begin
                    // entry 0 is written by the memory port this cycle
                    r_valid    <= TABLE_ENTRIES'(r_cap != '0);
                    r_count    <= CW'(r_cap != '0);
                    r_state    <= r_init_res ? S_DONE : S_IDLE;
                end
                S_SCAN: begin
                    // issue side
                    r_stg_vld <= r_issue;
                    r_stg_idx <= r_idx;
                    if (r_issue) begin
                        if (r_idx == LAST_IDX) begin
                            r_issue <= 1'b0;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                    // evaluate side
                    if (r_stg_vld) begin
                        if (r_mode == brfa_pkg::MODE_ALLOC) begin
                            if (stg_valid && fits && better) begin
                                r_found      <= 1'b1;
                                r_best_idx   <= r_stg_idx;
                                r_best_start <= r_rd.start;
                                r_best_len   <= r_rd.length;
                            end
                        end else if (stg_valid) begin
                            if (({1'b0, r_rd.start} < r_end) && ({1'b0, r_off} < stg_end)) begin
                                r_overlap <= 1'b1;
                            end
                            if (stg_end == {1'b0, r_off}) begin
                                r_pred       <= 1'b1;
                                r_pred_idx   <= r_stg_idx;
                                r_pred_start <= r_rd.start;
                                r_pred_len   <= r_rd.length;
                            end
                            if ({1'b0, r_rd.start} == r_end) begin
                                r_succ     <= 1'b1;
                                r_succ_idx <= r_stg_idx;
                                r_succ_len <= r_rd.length;
                            end
                        end else if (!r_slot) begin
                            r_slot     <= 1'b1;
                            r_slot_idx <= r_stg_idx;
                        end
                        if (r_stg_idx == LAST_IDX) begin
                            r_state <= S_UPD;
                        end
                    end
                end
                S_UPD: begin
                    r_status <= upd_status;
                    if (r_mode == brfa_pkg::MODE_ALLOC && r_found) begin
                        r_grant <= r_best_start;
                    end
                    if (upd_clr) begin
                        r_valid[upd_clr_idx] <= 1'b0;
                        r_count              <= r_count - 1'b1;
                    end
                    if (upd_set) begin
                        r_valid[r_slot_idx] <= 1'b1;
                        r_count             <= r_count + 1'b1;
                    end
                    r_stg_vld <= 1'b0;
                    r_state   <= S_DONE;
                end
                S_DONE: begin
                    // hand the result to the output register once it is free
                    if (out_free) begin
                        r_o_vld    <= 1'b1;
                        r_o_status <= r_status;
                        r_o_grant  <= r_grant;
                        r_o_free   <= count_ext[brfa_pkg::FREE_BITS-1:0];
                        r_init_res <= 1'b0;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Block count tracks the valid flags
    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == int'(r_count))
        else $error("free block count out of step with valid flags");

    // The scan pipeline only carries data while scanning
    a_stage_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stg_vld |-> (r_state == S_SCAN))
        else $error("scan stage active outside the scan");

    // Only a release can end out of range
    a_range_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_status == brfa_pkg::ST_RANGE)
            |-> (r_mode == brfa_pkg::MODE_RELEASE))
        else $error("range status on a non-release word");

    // A grant is only given by an allocate that succeeded
    a_grant_alloc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_grant != '0)
            |-> (r_mode == brfa_pkg::MODE_ALLOC && r_status == brfa_pkg::ST_OK))
        else $error("offset granted without a successful allocate");

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
`default_nettype none

module tb;

    localparam int TABLE_DEPTH  = 32;
    localparam int DRAIN_CYCLES = 48;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]                       mode;
        logic [brfa_pkg::OFFSET_BITS-1:0] size;
        logic [brfa_pkg::OFFSET_BITS-1:0] offset;
    } t_req_word;

    typedef struct packed {
        logic [1:0]                       status;
        logic [brfa_pkg::OFFSET_BITS-1:0] offset;
        logic [brfa_pkg::FREE_BITS-1:0]   free_cnt;
    } t_rsp_word;

    // A range the stimulus holds as allocated and may hand back later
    typedef struct {
        int unsigned base;
        int unsigned len;
    } t_held_range;

    // Free-list predictor plus the queue of result words still owed by the block
    class free_list_scoreboard;
        brfa_pkg::t_entry                 blocks[TABLE_DEPTH];
        bit                               in_use[TABLE_DEPTH];
        logic [brfa_pkg::OFFSET_BITS-1:0] cap_reg;
        logic [brfa_pkg::OFFSET_BITS-1:0] cap_live;
        t_rsp_word                        expected_results[$];
        int                               errors;

        function new();
            errors  = 0;
            cap_reg = '1;
            rebuild_table();
        endfunction

        // One free block spanning the latched capacity, or none at all
        function void rebuild_table();
            cap_live = cap_reg;
            foreach (blocks[i]) begin
                blocks[i] = '0;
                in_use[i] = 1'b0;
            end
            if (cap_live != 0) begin
                blocks[0].length = {1'b0, cap_live};
                in_use[0]        = 1'b1;
            end
        endfunction

        // Smallest block that fits, lowest start on ties; remainder stays free
        function logic [1:0] predict_alloc(input int unsigned size,
                                           output int unsigned granted);
            int best;
            best    = -1;
            granted = 0;
            if (size > cap_live)
                return brfa_pkg::ST_NOFIT;
            if (size == 0)
                return brfa_pkg::ST_OK;
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                if (!in_use[i] || blocks[i].length < size)
                    continue;
                if (best < 0 || blocks[i].length < blocks[best].length ||
                    (blocks[i].length == blocks[best].length &&
                     blocks[i].start < blocks[best].start))
                    best = i;
            end
            if (best < 0)
                return brfa_pkg::ST_NOFIT;
            granted = blocks[best].start;
            if (blocks[best].length > size) begin
                blocks[best].start  = blocks[best].start + size;
                blocks[best].length = blocks[best].length - size;
            end else begin
                in_use[best] = 1'b0;
            end
            return brfa_pkg::ST_OK;
        endfunction

        // Bounds and overlap checks, then coalesce with neighbours on either or both sides, or take a free slot
        function logic [1:0] predict_release(input int unsigned off, input int unsigned size);
            int unsigned last;
            int unsigned blk_end;
            int          pred;
            int          succ;
            int          slot;
            pred = -1;
            succ = -1;
            slot = -1;
            if (size == 0)
                return brfa_pkg::ST_OK;
            if (off > cap_live || size > int'(cap_live) - off)
                return brfa_pkg::ST_RANGE;
            last = off + size;
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                if (!in_use[i])
                    continue;
                blk_end = blocks[i].start + blocks[i].length;
                if (blocks[i].start < last && off < blk_end)
                    return brfa_pkg::ST_RANGE;
                if (blk_end == off)
                    pred = i;
                if (blocks[i].start == last)
                    succ = i;
            end
            if (pred >= 0 && succ >= 0) begin
                blocks[pred].length = blocks[pred].length + size + blocks[succ].length;
                in_use[succ] = 1'b0;
            end else if (pred >= 0) begin
                blocks[pred].length = blocks[pred].length + size;
            end else if (succ >= 0) begin
                blocks[succ].start  = off;
                blocks[succ].length = blocks[succ].length + size;
            end else begin
                for (int i = 0; i < TABLE_DEPTH; i++) begin
                    if (!in_use[i]) begin
                        slot = i;
                        break;
                    end
                end
                if (slot < 0)
                    return brfa_pkg::ST_FULL;
                blocks[slot].start  = off;
                blocks[slot].length = size;
                in_use[slot]        = 1'b1;
            end
            return brfa_pkg::ST_OK;
        endfunction

        // Called for each accepted request word; returns the word it will cause
        function t_rsp_word note_request(input t_req_word w);
            t_rsp_word   e;
            int unsigned granted;
            int          n;
            e       = '0;
            granted = 0;
            n       = 0;
            case (w.mode)
                brfa_pkg::MODE_ALLOC:   e.status = predict_alloc(w.size, granted);
                brfa_pkg::MODE_RELEASE: e.status = predict_release(w.offset, w.size);
                brfa_pkg::MODE_REINIT:  rebuild_table();
                default:                e.status = brfa_pkg::ST_OK;
            endcase
            foreach (in_use[i])
                if (in_use[i])
                    n++;
            e.offset   = granted[brfa_pkg::OFFSET_BITS-1:0];
            e.free_cnt = n[brfa_pkg::FREE_BITS-1:0];
            expected_results.insert(expected_results.size(), e);
            return e;
        endfunction

        // Called for each accepted result word
        function void check_result(input t_rsp_word got);
            t_rsp_word e;
            if (expected_results.size() == 0) begin
                errors++;
                $display("%0t: result with none expected: status %0d offset %0d blocks %0d",
                         $time, got.status, got.offset, got.free_cnt);
                return;
            end
            e = expected_results.pop_front();
            if (got.status !== e.status) begin
                errors++;
                $display("%0t: status mismatch: expected %0d actual %0d",
                         $time, e.status, got.status);
            end
            if (got.offset !== e.offset) begin
                errors++;
                $display("%0t: alloc_offset mismatch: expected %0d actual %0d",
                         $time, e.offset, got.offset);
            end
            if (got.free_cnt !== e.free_cnt) begin
                errors++;
                $display("%0t: free_blocks mismatch: expected %0d actual %0d",
                         $time, e.free_cnt, got.free_cnt);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    brfa_cfg_if cfg_bus();
    brfa_req_if req_bus();
    brfa_rsp_if rsp_bus();

    free_list_scoreboard sb = new();
    t_held_range         held[$];
    int                  tx_idle_pct = 16;
    int                  rx_idle_pct = 79;
    int                  sent_count  = 0;

    best_fit_range_allocator i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_bus),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Hard stop in case the block hangs
    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Result side: random back-pressure, every taken word checked
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_bus.valid && rsp_bus.ready)
            sb.check_result({rsp_bus.status, rsp_bus.alloc_offset, rsp_bus.free_blocks});
        rsp_bus.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // Send one request word, predict its result, track held ranges
    task automatic issue(input logic [1:0] mode, input int unsigned size,
                         input int unsigned off, output t_rsp_word e);
        t_req_word w;
        bit        idled;
        w     = {mode, size[brfa_pkg::OFFSET_BITS-1:0], off[brfa_pkg::OFFSET_BITS-1:0]};
        idled = 1'b0;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            if (!idled)
                req_bus.valid <= 1'b0;
            idled = 1'b1;
            @(posedge i_clk);
        end
        req_bus.valid      <= 1'b1;
        req_bus.mode       <= w.mode;
        req_bus.req_size   <= w.size;
        req_bus.req_offset <= w.offset;
        do @(posedge i_clk); while (req_bus.ready !== 1'b1);
        e = sb.note_request(w);

        if (w.mode == brfa_pkg::MODE_REINIT)
            held.delete();
        else if (w.mode == brfa_pkg::MODE_ALLOC && e.status == brfa_pkg::ST_OK && w.size != 0)
            held.insert(held.size(), '{e.offset, w.size});

        // idling pattern moves on with the word count
        sent_count++;
        if (sent_count == 240) begin
            tx_idle_pct = 79;
            rx_idle_pct = 16;
        end else if (sent_count == 480) begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
        end
    endtask

    // Hold off until every result is back, then let the block settle
    task automatic quiesce();
        req_bus.valid <= 1'b0;
        while (sb.expected_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [brfa_pkg::OFFSET_BITS-1:0] v);
        cfg_bus.valid          <= 1'b1;
        cfg_bus.arena_capacity <= v;
        do @(posedge i_clk); while (cfg_bus.ready !== 1'b1);
        sb.cap_reg = v;
        cfg_bus.valid <= 1'b0;
    endtask

    // Hand back a whole held range, or a prefix, suffix or middle piece of it
    task automatic release_held();
        int          idx;
        int          kind;
        int unsigned b;
        int unsigned l;
        int unsigned ps;
        int unsigned pl;
        t_rsp_word   e;
        idx  = $urandom_range(0, held.size() - 1);
        b    = held[idx].base;
        l    = held[idx].len;
        kind = (l < 3) ? 0 : $urandom_range(0, 3);
        case (kind)
            0: begin
                ps = b;
                pl = l;
            end
            1: begin
                ps = b;
                pl = $urandom_range(1, l - 1);
            end
            2: begin
                pl = $urandom_range(1, l - 1);
                ps = b + l - pl;
            end
            default: begin
                ps = b + $urandom_range(1, l - 2);
                pl = $urandom_range(1, b + l - 1 - ps);
            end
        endcase
        issue(brfa_pkg::MODE_RELEASE, pl, ps, e);
        if (e.status != brfa_pkg::ST_OK)
            return;
        case (kind)
            0: held.delete(idx);
            1: begin
                held[idx].base = b + pl;
                held[idx].len  = l - pl;
            end
            2: held[idx].len = l - pl;
            default: begin
                held[idx].len = ps - b;
                held.insert(held.size(), '{ps + pl, b + l - ps - pl});
            end
        endcase
    endtask

    // Punch isolated holes into one allocation until the table overflows
    task automatic fragment_table();
        t_rsp_word   e;
        int unsigned b;
        issue(brfa_pkg::MODE_ALLOC, 128, 0, e);
        if (e.status != brfa_pkg::ST_OK)
            return;
        held.delete(held.size() - 1);
        b = e.offset;
        for (int k = 0; k < 36; k++)
            issue(brfa_pkg::MODE_RELEASE, 1, b + 2 * k + 1, e);
    endtask

    // Release that is likely bad: random range, or lands on free space
    task automatic stray_release();
        int          picks[$];
        int          i;
        int unsigned s;
        t_rsp_word   e;
        case ($urandom_range(0, 2))
            0: issue(brfa_pkg::MODE_RELEASE, $urandom_range(0, 65535),
                     $urandom_range(0, 65535), e);
            1: issue(brfa_pkg::MODE_RELEASE, $urandom_range(1, 64),
                     $urandom_range(0, sb.cap_live), e);
            default: begin
                foreach (sb.in_use[j])
                    if (sb.in_use[j])
                        picks.insert(picks.size(), j);
                if (picks.size() == 0) begin
                    issue(brfa_pkg::MODE_RELEASE, $urandom_range(1, 64),
                          $urandom_range(0, sb.cap_live), e);
                end else begin
                    i = picks[$urandom_range(0, picks.size() - 1)];
                    s = sb.blocks[i].start + $urandom_range(0, sb.blocks[i].length - 1);
                    issue(brfa_pkg::MODE_RELEASE, $urandom_range(1, 16), s, e);
                end
            end
        endcase
    endtask

    task automatic random_item();
        int          r;
        int unsigned size;
        t_rsp_word   e;
        r = $urandom_range(0, 999);
        if (r < 15) begin
            fragment_table();
        end else if (r < 25) begin
            quiesce();
        end else if (r < 800 && r >= 420 && held.size() != 0) begin
            release_held();
        end else if (r < 800) begin
            r = $urandom_range(0, 99);
            if (r < 3)
                size = 0;
            else if (r < 70)
                size = $urandom_range(1, 64);
            else if (r < 92)
                size = $urandom_range(65, 4096);
            else
                size = $urandom_range(0, 65535);
            issue(brfa_pkg::MODE_ALLOC, size, $urandom_range(0, 65535), e);
        end else if (r < 900) begin
            stray_release();
        end else if (r < 930) begin
            issue(brfa_pkg::MODE_REINIT, $urandom_range(0, 65535), $urandom_range(0, 65535), e);
        end else if (r < 960) begin
            issue(MODE_UNUSED, $urandom_range(0, 65535), $urandom_range(0, 65535), e);
        end else begin
            issue(2'($urandom_range(0, 3)), $urandom_range(0, 65535),
                  $urandom_range(0, 65535), e);
        end
    endtask

    // Main sequence: reset, directed words, then capacity phases of random traffic
    initial begin
        int unsigned phase_cap[6];
        int          phase_len[6];
        t_rsp_word   e;

        phase_cap = '{0, 1, 300, 65535, 0, 2048};
        phase_len = '{20, 25, 95, 100, 95, 100};

        i_rst_n                <= 1'b0;
        req_bus.valid          <= 1'b0;
        req_bus.mode           <= brfa_pkg::MODE_ALLOC;
        req_bus.req_size       <= '0;
        req_bus.req_offset     <= '0;
        cfg_bus.valid          <= 1'b0;
        cfg_bus.arena_capacity <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: zero sizes, bounds, overlap, merges, exhaustion, ties
        issue(brfa_pkg::MODE_ALLOC,   0,     0,     e);
        issue(brfa_pkg::MODE_ALLOC,   100,   0,     e);
        issue(brfa_pkg::MODE_ALLOC,   200,   0,     e);
        issue(brfa_pkg::MODE_RELEASE, 0,     0,     e);
        issue(brfa_pkg::MODE_RELEASE, 1,     65535, e);
        issue(brfa_pkg::MODE_RELEASE, 1000,  65000, e);
        issue(brfa_pkg::MODE_RELEASE, 100,   0,     e);
        issue(brfa_pkg::MODE_RELEASE, 10,    50,    e);
        issue(brfa_pkg::MODE_RELEASE, 200,   100,   e);
        issue(brfa_pkg::MODE_ALLOC,   65535, 0,     e);
        issue(brfa_pkg::MODE_ALLOC,   1,     0,     e);
        issue(brfa_pkg::MODE_RELEASE, 65535, 0,     e);
        issue(MODE_UNUSED,            65535, 65535, e);
        issue(brfa_pkg::MODE_ALLOC,   40000, 0,     e);
        issue(brfa_pkg::MODE_RELEASE, 0,     65535, e);
        issue(brfa_pkg::MODE_RELEASE, 5000,  20000, e);
        issue(brfa_pkg::MODE_ALLOC,   5000,  0,     e);
        issue(brfa_pkg::MODE_RELEASE, 1,     39999, e);
        issue(brfa_pkg::MODE_RELEASE, 1,     0,     e);
        issue(brfa_pkg::MODE_RELEASE, 1,     1,     e);
        issue(brfa_pkg::MODE_REINIT,  0,     0,     e);
        issue(brfa_pkg::MODE_ALLOC,   30,    0,     e);
        issue(brfa_pkg::MODE_RELEASE, 5,     20,    e);
        issue(brfa_pkg::MODE_RELEASE, 5,     5,     e);
        issue(brfa_pkg::MODE_ALLOC,   5,     0,     e);

        // capacity phases; the new value only lands with a reinit
        phase_cap[4] = $urandom_range(1, 65535);
        for (int p = 0; p < 6; p++) begin
            quiesce();
            write_capacity(phase_cap[p][brfa_pkg::OFFSET_BITS-1:0]);
            issue(brfa_pkg::MODE_REINIT, 0, 0, e);
            for (int n = 0; n < phase_len[p]; n++)
                random_item();
        end

        quiesce();
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire
